FILE: sv/shape_pair_collision_test_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shape pair collision test unit
// Concurrent property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHAPE_PAIR_COLLISION_TEST_UNIT_MACROS_SVH
`define SHAPE_PAIR_COLLISION_TEST_UNIT_MACROS_SVH

// same-cycle implication
`define SPCT_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("spct same-cycle check failed");

// next-cycle implication
`define SPCT_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("spct next-cycle check failed");

`endif

FILE: sv/spct_pkg.sv
// ----------------------------------------------------------------------------
// spct_pkg
// Pair-kind codes for the shape pair collision test unit.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam logic [1:0] CMD_SQ_SQ = 2'd0;  // square a, square b
  localparam logic [1:0] CMD_SQ_CI = 2'd1;  // square a, circle b
  localparam logic [1:0] CMD_CI_SQ = 2'd2;  // circle a, square b
  localparam logic [1:0] CMD_CI_CI = 2'd3;  // circle a, circle b

endpackage

FILE: sv/spct_square.sv
// ----------------------------------------------------------------------------
// spct_square
// Exact square of a signed coordinate difference.
// ----------------------------------------------------------------------------
module spct_square #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS+1:0]   d,
  output logic        [2*COORD_BITS+1:0] sq
);

  localparam int DW  = COORD_BITS + 2;
  localparam int SQW = 2 * COORD_BITS + 2;

  logic signed [2*DW-1:0] prod;

  assign prod = d * d;
  assign sq   = prod[SQW-1:0];

endmodule

FILE: sv/shape_pair_collision_test_unit.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test_unit
// Square/circle pair collision judge, one request a cycle when not stalled.
// ----------------------------------------------------------------------------
// Accepts one shape pair request per clock while in_stall is low and
// returns one hit flag per request, in order. A request passes four
// register stages: the input register, the difference stage (box tests
// and coordinate differences), the square stage (five exact multipliers)
// and the result register, which drives out_valid. Stall on the result
// side backs up through the stages; in_stall rises only once every stage
// is full.
module shape_pair_collision_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-2:0]        in_a_extent,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-2:0]        in_b_extent,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit
);

  import spct_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 2;
  localparam int SQW  = 2 * CB + 2;
  localparam int SUMW = SQW + 1;

  // pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en0, en1, en2, en3;

  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v3_r || en3;
  assign en1      = !v2_r || en2;
  assign en0      = !v1_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en0) v1_r <= in_valid;
      if (en1) v2_r <= v1_r;
      if (en2) v3_r <= v2_r;
      if (en3) out_valid_r <= v3_r;
    end
  end

  // stage 1: input register
  logic [1:0]           cmd1_r;
  logic signed [CB-1:0] ax1_r, ay1_r, bx1_r, by1_r;
  logic [CB-2:0]        ae1_r, be1_r;

  always_ff @(posedge clk) begin
    if (en0) begin
      cmd1_r <= in_cmd;
      ax1_r  <= in_a_x;
      ay1_r  <= in_a_y;
      ae1_r  <= in_a_extent;
      bx1_r  <= in_b_x;
      by1_r  <= in_b_y;
      be1_r  <= in_b_extent;
    end
  end

  // stage 2: box tests and differences
  logic signed [DW-1:0] ax, ay, ae, bx, by, be;
  logic signed [DW-1:0] sx, sy, ss, cx, cy, rr, right, top;
  logic                 box_hit_nxt, coarse_ok_nxt, center_in_nxt;
  logic signed [DW-1:0] d0_nxt, d1_nxt, e0_nxt, e1_nxt, rad_nxt;

  assign ax = {{2{ax1_r[CB-1]}}, ax1_r};
  assign ay = {{2{ay1_r[CB-1]}}, ay1_r};
  assign bx = {{2{bx1_r[CB-1]}}, bx1_r};
  assign by = {{2{by1_r[CB-1]}}, by1_r};
  assign ae = {3'b000, ae1_r};
  assign be = {3'b000, be1_r};

  always_comb begin
    if (cmd1_r == CMD_CI_SQ) begin
      sx = bx; sy = by; ss = be;
      cx = ax; cy = ay; rr = ae;
    end else begin
      sx = ax; sy = ay; ss = ae;
      cx = bx; cy = by; rr = be;
    end
    right = sx + ss;
    top   = sy + ss;

    box_hit_nxt   = !((bx > ax + ae) || (bx + be < ax) || (by + be < ay) || (by > ay + ae));
    coarse_ok_nxt = !((cx - rr > right) || (cx + rr < sx) || (cy + rr < sy) || (cy - rr > top));
    center_in_nxt = (sx < cx) && (right > cx) && (sy < cy) && (top > cy);

    if (cmd1_r == CMD_CI_CI) begin
      d0_nxt  = bx - ax;
      d1_nxt  = '0;
      e0_nxt  = ay - by;
      e1_nxt  = '0;
      rad_nxt = ae + be;
    end else begin
      d0_nxt  = sx - cx;
      d1_nxt  = right - cx;
      e0_nxt  = sy - cy;
      e1_nxt  = top - cy;
      rad_nxt = rr;
    end
  end

  logic [1:0]           cmd2_r;
  logic                 box_hit2_r, coarse_ok2_r, center_in2_r;
  logic signed [DW-1:0] d0_r, d1_r, e0_r, e1_r, rad_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd2_r       <= cmd1_r;
      box_hit2_r   <= box_hit_nxt;
      coarse_ok2_r <= coarse_ok_nxt;
      center_in2_r <= center_in_nxt;
      d0_r         <= d0_nxt;
      d1_r         <= d1_nxt;
      e0_r         <= e0_nxt;
      e1_r         <= e1_nxt;
      rad_r        <= rad_nxt;
    end
  end

  // stage 3: squares
  logic [SQW-1:0] sq_d0, sq_d1, sq_e0, sq_e1, sq_rad;

  spct_square #(.COORD_BITS(COORD_BITS)) u_sq_d0  (.d(d0_r),  .sq(sq_d0));
  spct_square #(.COORD_BITS(COORD_BITS)) u_sq_d1  (.d(d1_r),  .sq(sq_d1));
  spct_square #(.COORD_BITS(COORD_BITS)) u_sq_e0  (.d(e0_r),  .sq(sq_e0));
  spct_square #(.COORD_BITS(COORD_BITS)) u_sq_e1  (.d(e1_r),  .sq(sq_e1));
  spct_square #(.COORD_BITS(COORD_BITS)) u_sq_rad (.d(rad_r), .sq(sq_rad));

  logic [1:0]     cmd3_r;
  logic           box_hit3_r, coarse_ok3_r, center_in3_r;
  logic [SQW-1:0] sq_d0_r, sq_d1_r, sq_e0_r, sq_e1_r, sq_rad_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd3_r       <= cmd2_r;
      box_hit3_r   <= box_hit2_r;
      coarse_ok3_r <= coarse_ok2_r;
      center_in3_r <= center_in2_r;
      sq_d0_r      <= sq_d0;
      sq_d1_r      <= sq_d1;
      sq_e0_r      <= sq_e0;
      sq_e1_r      <= sq_e1;
      sq_rad_r     <= sq_rad;
    end
  end

  // stage 4: distance compares and result
  logic [SUMW-1:0] dist00, dist10, dist01, dist11, rad_sq;
  logic            corner_in;
  logic            hit_nxt;
  logic            hit_r;

  assign dist00 = {1'b0, sq_d0_r} + {1'b0, sq_e0_r};
  assign dist10 = {1'b0, sq_d1_r} + {1'b0, sq_e0_r};
  assign dist01 = {1'b0, sq_d0_r} + {1'b0, sq_e1_r};
  assign dist11 = {1'b0, sq_d1_r} + {1'b0, sq_e1_r};
  assign rad_sq = {1'b0, sq_rad_r};

  assign corner_in = (dist00 < rad_sq) || (dist10 < rad_sq) ||
                     (dist01 < rad_sq) || (dist11 < rad_sq);

  always_comb begin
    case (cmd3_r)
      CMD_SQ_SQ: hit_nxt = box_hit3_r;
      CMD_SQ_CI,
      CMD_CI_SQ: hit_nxt = coarse_ok3_r && (corner_in || center_in3_r);
      CMD_CI_CI: hit_nxt = (dist00 <= rad_sq);
      default:   hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) hit_r <= hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;

endmodule

FILE: sv/spct_checker.sv
// ----------------------------------------------------------------------------
// spct_checker
// Port-level checks for the shape pair collision test unit, bound to it.
// ----------------------------------------------------------------------------
`include "shape_pair_collision_test_unit_macros.svh"

module spct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  // an empty result register never backs up the input
  `SPCT_ASSERT_NOW(a_empty_no_stall, clk, rst_n, !out_valid, !in_stall)

  // stall on the input only comes from stall on the output
  `SPCT_ASSERT_NOW(a_stall_source, clk, rst_n, in_stall, out_valid && out_stall)

  // a held result stays put
  `SPCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_hit))

  // a full pipe under stall keeps the input stalled
  `SPCT_ASSERT_NEXT(a_full_stays, clk, rst_n, in_valid && in_stall && out_stall,
                    in_stall || !out_stall)

endmodule

bind shape_pair_collision_test_unit spct_checker u_spct_checker (.*);

FILE: verif/shape_pair_collision_test_unit_tb.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test_unit_tb
// Self-checking bench for the shape pair collision test unit.
// ----------------------------------------------------------------------------
// Drives shape pair requests of all four pair kinds. It starts with directed
// touching, boundary and extreme cases, then random pairs, half of them
// clustered so that hits and near misses are common. Traffic runs in phases:
// no idling, sender gaps, receiver stalls, both, and a long receiver
// hold-off that backs the pipeline up into in_stall. A scoreboard predicts
// each hit flag with exact integer geometry and checks results in order.

typedef struct {
  logic [1:0]         cmd;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic [14:0]        a_extent;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic [14:0]        b_extent;
} pair_req_t;

class hit_scoreboard;
  pair_req_t pending_req[$];
  bit        pending_hit[$];
  int        mismatches;

  function longint sq_dist(longint px, longint py, longint cx, longint cy);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy);
  endfunction

  function bit square_circle(longint sx, longint sy, longint ss,
                             longint cx, longint cy, longint r);
    longint right, top, rr;
    right = sx + ss;
    top   = sy + ss;
    rr    = r * r;
    if (cx - r > right || cx + r < sx || cy + r < sy || cy - r > top) return 1'b0;
    if (sq_dist(sx, sy, cx, cy) < rr || sq_dist(right, sy, cx, cy) < rr ||
        sq_dist(sx, top, cx, cy) < rr || sq_dist(right, top, cx, cy) < rr)
      return 1'b1;
    return sx < cx && right > cx && sy < cy && top > cy;
  endfunction

  function bit judge(pair_req_t r);
    longint ax, ay, ae, bx, by, be, rs;
    ax = r.a_x;
    ay = r.a_y;
    ae = r.a_extent;
    bx = r.b_x;
    by = r.b_y;
    be = r.b_extent;
    case (r.cmd)
      spct_pkg::CMD_SQ_SQ: return !(bx > ax + ae || bx + be < ax || by + be < ay || by > ay + ae);
      spct_pkg::CMD_SQ_CI: return square_circle(ax, ay, ae, bx, by, be);
      spct_pkg::CMD_CI_SQ: return square_circle(bx, by, be, ax, ay, ae);
      default: begin
        rs = ae + be;
        return sq_dist(ax, ay, bx, by) <= rs * rs;
      end
    endcase
  endfunction

  function void note_request(pair_req_t r);
    pending_req.push_back(r);
    pending_hit.push_back(judge(r));
  endfunction

  function void check_hit(bit got);
    pair_req_t r;
    bit        exp_hit;
    if (pending_hit.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: hit=%0d", got);
      return;
    end
    r       = pending_req.pop_front();
    exp_hit = pending_hit.pop_front();
    if (got !== exp_hit) begin
      mismatches++;
      if (mismatches <= 10)
        $display("hit mismatch: cmd=%0d a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) exp=%0d got=%0d",
                 r.cmd, r.a_x, r.a_y, r.a_extent, r.b_x, r.b_y, r.b_extent,
                 exp_hit, got);
    end
  endfunction

  function int waiting();
    return pending_hit.size();
  endfunction
endclass

module shape_pair_collision_test_unit_tb;
  import spct_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_SQ_SQ;
  logic signed [15:0] in_a_x = '0;
  logic signed [15:0] in_a_y = '0;
  logic [14:0]        in_a_extent = '0;
  logic signed [15:0] in_b_x = '0;
  logic signed [15:0] in_b_y = '0;
  logic [14:0]        in_b_extent = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;

  int            idle_pct;
  int            stall_pct;
  int            hold_cycles;
  hit_scoreboard sb;

  shape_pair_collision_test_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_a_x      (in_a_x),
    .in_a_y      (in_a_y),
    .in_a_extent (in_a_extent),
    .in_b_x      (in_b_x),
    .in_b_y      (in_b_y),
    .in_b_extent (in_b_extent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: long hold-off first, random stall otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_hit(out_hit);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic pair_req_t mk(logic [1:0] c, int ax, int ay, int ae,
                                   int bx, int by, int be);
    pair_req_t r;
    r.cmd      = c;
    r.a_x      = 16'(ax);
    r.a_y      = 16'(ay);
    r.a_extent = 15'(ae);
    r.b_x      = 16'(bx);
    r.b_y      = 16'(by);
    r.b_extent = 15'(be);
    return r;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic pair_req_t random_pair();
    pair_req_t r;
    int        kind, span, base_x, base_y;
    kind = $urandom_range(3);
    if (kind == 0) begin
      r = mk(2'($urandom_range(3)), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    end else if (kind == 3) begin
      r = mk(2'($urandom_range(3)), corner_value(), corner_value(),
             ($urandom_range(1) ? 32767 : $urandom_range(1)),
             corner_value(), corner_value(),
             ($urandom_range(1) ? 32767 : $urandom_range(1)));
    end else begin
      span   = (kind == 1) ? 256 : 4096;
      base_x = $urandom;
      base_y = $urandom;
      r = mk(2'($urandom_range(3)),
             base_x + int'($urandom_range(2 * span)) - span,
             base_y + int'($urandom_range(2 * span)) - span,
             $urandom_range(span),
             base_x + int'($urandom_range(2 * span)) - span,
             base_y + int'($urandom_range(2 * span)) - span,
             $urandom_range(span));
    end
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(pair_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= r.cmd;
    in_a_x      <= r.a_x;
    in_a_y      <= r.a_y;
    in_a_extent <= r.a_extent;
    in_b_x      <= r.b_x;
    in_b_y      <= r.b_y;
    in_b_extent <= r.b_extent;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic set_traffic(int idle, int stall, int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    idle_pct    = idle;
    stall_pct   = stall;
    hold_cycles = hold;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_pair());
  endtask

  initial begin
    int drain;
    sb          = new();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // square-square: extremes, touching edge, just apart, zero sides
    send_request(mk(CMD_SQ_SQ, -32768, -32768, 32767, 32767, 32767, 32767));
    send_request(mk(CMD_SQ_SQ, 0, 0, 160, 160, 0, 80));
    send_request(mk(CMD_SQ_SQ, 0, 0, 160, 161, 0, 80));
    send_request(mk(CMD_SQ_SQ, 5, 5, 0, 5, 5, 0));
    send_request(mk(CMD_SQ_SQ, -1, -1, 32767, -32768, -32768, 32767));
    // circle-circle: touching, just apart, extremes, zero radii
    send_request(mk(CMD_CI_CI, 0, 0, 480, 800, 0, 320));
    send_request(mk(CMD_CI_CI, 0, 0, 480, 801, 0, 320));
    send_request(mk(CMD_CI_CI, -32768, -32768, 32767, 32767, 32767, 32767));
    send_request(mk(CMD_CI_CI, 32767, -32768, 32767, -32768, 32767, 32767));
    send_request(mk(CMD_CI_CI, 7, -7, 0, 7, -7, 0));
    send_request(mk(CMD_CI_CI, 7, -7, 0, 8, -7, 0));
    // square-circle: coarse miss, corner inside, corner on rim,
    // centre inside, centre on edge
    send_request(mk(CMD_SQ_CI, 0, 0, 160, 400, 0, 100));
    send_request(mk(CMD_SQ_CI, 0, 0, 160, -30, -40, 60));
    send_request(mk(CMD_SQ_CI, 0, 0, 160, -48, -64, 80));
    send_request(mk(CMD_SQ_CI, 0, 0, 160, 80, 80, 16));
    send_request(mk(CMD_SQ_CI, 0, 0, 160, 80, 0, 16));
    send_request(mk(CMD_SQ_CI, 10, 10, 0, 0, 0, 100));
    send_request(mk(CMD_SQ_CI, 32767, 32767, 32767, -32768, -32768, 32767));
    // circle-square mirrors
    send_request(mk(CMD_CI_SQ, -30, -40, 60, 0, 0, 160));
    send_request(mk(CMD_CI_SQ, 80, 80, 0, 0, 0, 160));
    send_request(mk(CMD_CI_SQ, -48, -64, 80, 0, 0, 160));
    send_request(mk(CMD_CI_SQ, 0, 0, 32767, -32768, -32768, 32767));
    send_request(mk(CMD_CI_SQ, 32767, -32768, 32767, 32767, 32767, 32767));

    send_random(140);
    set_traffic(57, 0, 0);
    send_random(140);
    set_traffic(0, 57, 0);
    send_random(140);
    set_traffic(28, 28, 0);
    send_random(140);
    set_traffic(0, 0, 64);
    send_random(100);

    in_valid <= 1'b0;
    drain = 0;
    while (sb.waiting() > 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/spct_pkg.sv
sv/spct_square.sv
sv/shape_pair_collision_test_unit.sv
sv/spct_checker.sv
verif/shape_pair_collision_test_unit_tb.sv
